/* src/ahs_pkg.sv */
package ahs_pkg;

   // Field and register widths fixed by the channel definitions
   localparam int ACTION_W     = 1;
   localparam int HINDEX_W     = 4;
   localparam int PHASE_IN_W   = 32;
   localparam int WEIGHT_W     = 16;
   localparam int SINE_W       = 16;
   localparam int SAMPLE_W     = 24;
   localparam int AMP_W        = 16;
   localparam int HCOUNT_W     = 5;
   localparam int SCOUNT_W     = 24;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;

   // Register reset values
   localparam logic [AMP_W-1:0]    AMP_RESET    = 16'd256;
   localparam logic [HCOUNT_W-1:0] HCOUNT_RESET = 5'd1;
   localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 24'd48000;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONIC_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT   = 2'd2;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD     = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_GENERATE = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_SCALE,
      ST_FINISH
   } state_type;

endpackage

/* src/ahs_req_if.sv */
interface ahs_req_if import ahs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [HINDEX_W-1:0]   harmonic_index;
   logic [PHASE_IN_W-1:0] phase_step;
   logic [PHASE_IN_W-1:0] start_phase;
   logic signed [WEIGHT_W-1:0] weight;

   modport source (
      output valid, action, harmonic_index, phase_step, start_phase, weight,
      input  ready
   );
   modport sink (
      input  valid, action, harmonic_index, phase_step, start_phase, weight,
      output ready
   );
endinterface

/* src/ahs_rsp_if.sv */
interface ahs_rsp_if import ahs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;
   logic                       clipped;

   modport source (
      output valid, sample, last, clipped,
      input  ready
   );
   modport sink (
      input  valid, sample, last, clipped,
      output ready
   );
endinterface

/* src/ahs_sine_rom.sv */
module ahs_sine_rom import ahs_pkg::*; #(
   parameter int SINE_ADDR_BITS = 12
) (
   input  logic                             clock,
   input  logic [SINE_ADDR_BITS-1:0]        angle,
   output logic signed [SINE_W-1:0]         sine
);

   localparam int QTR_W      = SINE_ADDR_BITS - 2;
   localparam int QUARTER    = 1 << QTR_W;
   localparam int ROM_ADDR_W = QTR_W + 1;
   localparam int MAG_W      = SINE_W - 1;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] MAG_MAX     = 64'd32767;

   // Q2.62 product, truncated
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // round(32767*sin(pi/2 * r/QUARTER)), odd Taylor series in Q62
   function automatic logic [MAG_W-1:0] sine_mag(input int unsigned r);
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  sum;
      logic [63:0]  mag;
      logic [127:0] prod;
      x   = mul_q62(HALF_PI_Q62, 64'(r) << (64 - SINE_ADDR_BITS));
      x2  = mul_q62(x, x);
      sum = x;
      t   = x;
      for (int unsigned n = 1; n <= 13; n++) begin
         t = mul_q62(t, x2) / 64'((2 * n) * (2 * n + 1));
         if (n[0]) begin
            sum = sum - t;
         end else begin
            sum = sum + t;
         end
      end
      prod = 128'(sum) * 128'(32767) + (128'd1 << 61);
      mag  = prod[125:62];
      if (mag > MAG_MAX) begin
         mag = MAG_MAX;
      end
      return mag[MAG_W-1:0];
   endfunction

   // Quarter-wave table, endpoints included
   logic [MAG_W-1:0] quarter_rom [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      localparam logic [MAG_W-1:0] MAG = sine_mag(g);
      assign quarter_rom[g] = MAG;
   end

   logic [1:0]            quadrant;
   logic [QTR_W-1:0]      offset;
   logic [ROM_ADDR_W-1:0] rom_addr;
   logic [MAG_W-1:0]      mag_ff;
   logic                  neg_ff;
   logic [MAG_W-1:0]      mag_in;
   logic                  neg_in;

   // Fold the angle onto the first quadrant
   always_comb begin
      quadrant = angle[SINE_ADDR_BITS-1 -: 2];
      offset   = angle[QTR_W-1:0];
      if (quadrant[0]) begin
         rom_addr = ROM_ADDR_W'(QUARTER) - {1'b0, offset};
      end else begin
         rom_addr = {1'b0, offset};
      end
      mag_in = quarter_rom[rom_addr];
      neg_in = quadrant[1];
   end

   // Registered table read
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   // Restore the sign of the lower half wave
   always_comb begin
      if (neg_ff) begin
         sine = -$signed({1'b0, mag_ff});
      end else begin
         sine = $signed({1'b0, mag_ff});
      end
   end

endmodule

/* src/additive_harmonic_synth_core.sv */
// Additive sine synthesizer.
// Requests arrive on req_chan (valid/ready). A load transaction writes one
// harmonic entry (phase step, start phase, weight) and returns nothing; an
// entry index at or beyond MAX_HARMONICS is dropped. A generate transaction
// returns one transaction on rsp_chan: the weighted sine sum of the first
// harmonic_count entries times amplitude, saturated to 24 bits, with last
// and clipped flags; afterwards every entry's phase advances by its step.
// Registers are written on the csr port (csr_we, csr_index, csr_wdata).
// A load leaves the block idle and ready for more requests. A generate
// keeps req_chan.ready low until its result enters the output register:
// one shared multiplier walks every entry through a four-stage read, sine
// lookup, multiply and accumulate pipeline, and then scales the sum.
// The result sits in an output register; a stalled receiver blocks only
// the next sample's completion, and loads are still taken while the block is idle.
// Reset (synchronous, active high) clears all harmonic entries, the sample
// counter and the registers to their defaults; the block is ready in the
// first cycle after reset.
module additive_harmonic_synth_core import ahs_pkg::*; #(
   parameter int MAX_HARMONICS  = 16,
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   ahs_req_if.sink                req_chan,
   ahs_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int CNT_W    = $clog2(MAX_HARMONICS + 1);
   localparam int SUM_W    = WEIGHT_W + CNT_W + 1;
   localparam int MULB_W   = AMP_W + 1;
   localparam int PROD_W   = SUM_W + MULB_W;
   localparam int SCALED_W = PROD_W - 8;
   localparam int OVF_W    = SCALED_W - SAMPLE_W + 1;

   // ---------------- configuration registers ----------------
   logic [AMP_W-1:0]    amp_ff, amp_in;
   logic [HCOUNT_W-1:0] hcount_ff, hcount_in;
   logic [SCOUNT_W-1:0] scount_ff, scount_in;

   always_comb begin
      amp_in    = amp_ff;
      hcount_in = hcount_ff;
      scount_in = scount_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AMPLITUDE:      amp_in    = csr_wdata[AMP_W-1:0];
            CSR_HARMONIC_COUNT: hcount_in = csr_wdata[HCOUNT_W-1:0];
            CSR_SAMPLE_COUNT:   scount_in = csr_wdata[SCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff    <= AMP_RESET;
         hcount_ff <= HCOUNT_RESET;
         scount_ff <= SCOUNT_RESET;
      end else begin
         amp_ff    <= amp_in;
         hcount_ff <= hcount_in;
         scount_ff <= scount_in;
      end
   end

   // ---------------- sequencer ----------------
   state_type state_ff, state_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             req_accept;
   logic             gen_accept;
   logic             load_we;
   logic             issue;
   logic             out_load;
   logic             pipe_busy;
   logic             s1_v_ff, s2_v_ff, s3_v_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign gen_accept = req_accept && (req_chan.action == ACT_GENERATE);
   assign load_we    = req_accept && (req_chan.action == ACT_LOAD) &&
                       (int'(req_chan.harmonic_index) < MAX_HARMONICS);
   assign pipe_busy  = s1_v_ff || s2_v_ff || s3_v_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (gen_accept) state_in = ST_WALK;
         ST_WALK:   if (32'(rd_ptr_ff) == MAX_HARMONICS - 1) state_in = ST_DRAIN;
         ST_DRAIN:  if (!pipe_busy) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: if (!rsp_chan.valid || rsp_chan.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      issue          = 1'b0;
      out_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_WALK:   issue = 1'b1;
         ST_FINISH: out_load = !rsp_chan.valid || rsp_chan.ready;
         default: ;
      endcase
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (gen_accept) begin
         rd_ptr_in = '0;
      end else if (issue) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ptr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // ---------------- harmonic entry memories ----------------
   logic [PHASE_BITS-1:0]      phase_mem  [MAX_HARMONICS];
   logic [PHASE_BITS-1:0]      step_mem   [MAX_HARMONICS];
   logic signed [WEIGHT_W-1:0] weight_mem [MAX_HARMONICS];
   logic [MAX_HARMONICS-1:0]   entry_valid_ff, entry_valid_in;

   logic [IDX_W-1:0]           load_addr;
   logic [IDX_W-1:0]           rd_addr;
   logic [PHASE_BITS-1:0]      phase_rd_ff;
   logic [PHASE_BITS-1:0]      step_rd_ff;
   logic signed [WEIGHT_W-1:0] weight_rd_ff;

   logic                       phase_we;
   logic [IDX_W-1:0]           phase_waddr;
   logic [PHASE_BITS-1:0]      phase_wdata;

   logic [IDX_W-1:0]           s1_addr_ff;
   logic                       s1_use_ff;
   logic                       s1_entry_valid;
   logic [PHASE_BITS-1:0]      s1_phase;
   logic [PHASE_BITS-1:0]      s1_step;
   logic signed [WEIGHT_W-1:0] s1_weight;

   assign load_addr = IDX_W'(req_chan.harmonic_index);
   assign rd_addr   = rd_ptr_ff[IDX_W-1:0];

   // Single write port: loads in idle, phase write-back during the walk and drain
   always_comb begin
      phase_we    = load_we || s1_v_ff;
      phase_waddr = load_we ? load_addr : s1_addr_ff;
      phase_wdata = load_we ? PHASE_BITS'(req_chan.start_phase) : s1_phase + s1_step;
   end

   always_ff @(posedge clock) begin
      if (phase_we) begin
         phase_mem[phase_waddr] <= phase_wdata;
      end
      if (load_we) begin
         step_mem[load_addr]   <= PHASE_BITS'(req_chan.phase_step);
         weight_mem[load_addr] <= req_chan.weight;
      end
      phase_rd_ff  <= phase_mem[rd_addr];
      step_rd_ff   <= step_mem[rd_addr];
      weight_rd_ff <= weight_mem[rd_addr];
   end

   // Entries never loaded read as zero
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (load_we) begin
         entry_valid_in[load_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   assign s1_entry_valid = entry_valid_ff[s1_addr_ff];
   assign s1_phase  = s1_entry_valid ? phase_rd_ff  : '0;
   assign s1_step   = s1_entry_valid ? step_rd_ff   : '0;
   assign s1_weight = s1_entry_valid ? weight_rd_ff : '0;

   // ---------------- sine lookup (stage 2) ----------------
   logic signed [SINE_W-1:0]   sine_val;
   logic signed [WEIGHT_W-1:0] s2_weight_ff;
   logic                       s2_use_ff;
   logic                       s3_use_ff;

   ahs_sine_rom #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_sine_rom (
      .clock (clock),
      .angle (s1_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]),
      .sine  (sine_val)
   );

   // ---------------- shared multiplier (stage 3 and scaling) ----------------
   logic signed [SUM_W-1:0]  mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   // Scaling operands stay selected through the finish step so a held
   // result keeps a stable product
   always_comb begin
      if (state_ff == ST_SCALE || state_ff == ST_FINISH) begin
         mul_a = sum_ff;
         mul_b = $signed({1'b0, amp_ff});
      end else begin
         mul_a = SUM_W'(s2_weight_ff);
         mul_b = MULB_W'(sine_val);
      end
      mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      mul_ff       <= mul_in;
      s1_addr_ff   <= rd_addr;
      s1_use_ff    <= 32'(rd_ptr_ff) < 32'(hcount_ff);
      s2_weight_ff <= s1_weight;
      s2_use_ff    <= s1_use_ff;
      s3_use_ff    <= s2_use_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // ---------------- accumulate (stage 4) ----------------
   logic signed [WEIGHT_W-1:0] term;

   // floor of product / 2^15; always fits the weight width
   assign term = mul_ff[15 +: WEIGHT_W];

   always_comb begin
      sum_in = sum_ff;
      if (gen_accept) begin
         sum_in = '0;
      end else if (s3_v_ff && s3_use_ff) begin
         sum_in = sum_ff + SUM_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // ---------------- scale, saturate, output register ----------------
   logic signed [SCALED_W-1:0] scaled;
   logic [OVF_W-1:0]           top_bits;
   logic                       overflow;
   logic signed [SAMPLE_W-1:0] sat_sample;
   logic                       last_flag;
   logic [SCOUNT_W-1:0]        sample_cnt_ff, sample_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_clipped_ff, rsp_clipped_in;

   always_comb begin
      scaled   = mul_ff[PROD_W-1:8];
      top_bits = scaled[SCALED_W-1:SAMPLE_W-1];
      overflow = !((&top_bits) || !(|top_bits));
      if (!overflow) begin
         sat_sample = scaled[SAMPLE_W-1:0];
      end else if (scaled[SCALED_W-1]) begin
         sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      last_flag = sample_cnt_ff == (scount_ff - 1'b1);
   end

   always_comb begin
      sample_cnt_in  = sample_cnt_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_clipped_in = rsp_clipped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_sample_in  = sat_sample;
         rsp_last_in    = last_flag;
         rsp_clipped_in = overflow;
         sample_cnt_in  = last_flag ? '0 : sample_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         sample_cnt_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         sample_cnt_ff <= sample_cnt_in;
      end
      rsp_sample_ff  <= rsp_sample_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.sample  = rsp_sample_ff;
   assign rsp_chan.last    = rsp_last_ff;
   assign rsp_chan.clipped = rsp_clipped_ff;

   // ---------------- assertions ----------------
   a_gen_starts_walk: assert property (@(posedge clock) disable iff (reset)
      gen_accept |=> (state_ff == ST_WALK) && (sum_ff == '0))
      else $error("generate did not start a clean walk");

   a_pipe_in_walk: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> (state_ff == ST_WALK) || (state_ff == ST_DRAIN))
      else $error("accumulate stage active outside the walk");

   a_scale_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> !pipe_busy && $past(state_ff == ST_DRAIN))
      else $error("scaling started with the pipeline still busy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result presented outside the finish step");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      load_we |-> !pipe_busy)
      else $error("entry load overlapped the walk");

endmodule
